// ===== rtl/core/vcsa_pkg.sv =====
// Package for the vertex cache slot assigner.
// Holds sizes, command codes, payload and control structs and the FSM type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vcsa_pkg;

  localparam int CACHE_SLOTS = 32;
  localparam int SLOT_W      = $clog2(CACHE_SLOTS);
  localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);

  localparam int SLOT_NUM_W  = 5;
  localparam int LIMIT_W     = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BATCH = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic signed [15:0]    buffer_id;
    logic signed [15:0]    vertex_number;
    logic signed [7:0]     matrix_number;
    logic                  last_in_batch;
  } item_t;

  typedef struct packed {
    logic [SLOT_NUM_W-1:0] assigned_slot;
    logic                  reused;
    logic                  overflow;
    logic                  last_result;
  } result_t;

  // Vertex identity as held in a slot; all ones is an empty slot.
  typedef struct packed {
    logic [15:0] buffer_id;
    logic [15:0] vertex_number;
    logic [7:0]  matrix_number;
  } ident_t;

  localparam ident_t IDENT_EMPTY = '1;

  // One collected batch vertex.
  typedef struct packed {
    logic              matched;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic             mark;
    logic             store;
    logic [CNT_W-1:0] store_pos;
    logic             shift_batch;
    logic             shift_used;
    logic             clear_used;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_STORE,
    ST_WALK
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/vcsa_cell.sv =====
// One slot cell: resident identity, in-use flag and one batch entry.
// Used flags and batch entries move one cell towards slot 0 on a shift.
// Depends on vcsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcsa_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [vcsa_pkg::CNT_W-1:0] idx_i,
  input  wire vcsa_pkg::cell_ctl_t     ctl_i,
  input  wire logic [vcsa_pkg::CNT_W-1:0] limit_i,
  input  wire logic                    wr_en_i,
  input  wire vcsa_pkg::ident_t        wr_ident_i,
  input  wire vcsa_pkg::ident_t        probe_i,
  input  wire vcsa_pkg::entry_t        store_entry_i,
  input  wire vcsa_pkg::entry_t        entry_next_i,
  input  wire logic                    used_next_i,
  output logic                         match_o,
  output vcsa_pkg::entry_t             entry_o,
  output logic                         used_o
);

  vcsa_pkg::ident_t ident_q;
  vcsa_pkg::entry_t entry_q;
  logic             used_q, used_d;

  assign match_o = (ident_q == probe_i) && (idx_i < limit_i);
  assign entry_o = entry_q;
  assign used_o  = used_q;

  always_comb begin
    used_d = used_q;
    if (ctl_i.clear_used) begin
      used_d = 1'b0;
    end else if (ctl_i.mark && match_o) begin
      used_d = 1'b1;
    end else if (ctl_i.shift_used) begin
      used_d = used_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q <= vcsa_pkg::IDENT_EMPTY;
      used_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        ident_q <= wr_ident_i;
      end
      used_q <= used_d;
    end
  end

  // batch payload, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.store && (ctl_i.store_pos == idx_i)) begin
      entry_q <= store_entry_i;
    end else if (ctl_i.shift_batch) begin
      entry_q <= entry_next_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcsa_ctrl.sv =====
// Sequencer: accepts transactions, holds the limit register, picks the highest
// match, and walks the batch at the head of the cell chain to hand out slots.
// Depends on vcsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcsa_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire vcsa_pkg::item_t                     item_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [vcsa_pkg::LIMIT_W-1:0]        cfg_wdata_i,
  input  wire logic [vcsa_pkg::CACHE_SLOTS-1:0]    match_i,
  input  wire vcsa_pkg::entry_t                    head_i,
  input  wire logic                                head_used_i,
  output logic                                     busy_o,
  output logic                                     wr_en_o,
  output vcsa_pkg::cell_ctl_t                      ctl_o,
  output logic [vcsa_pkg::CNT_W-1:0]               limit_o,
  output vcsa_pkg::ident_t                         probe_o,
  output vcsa_pkg::entry_t                         store_entry_o,
  output logic                                     result_valid_o,
  output vcsa_pkg::result_t                        result_o
);

  localparam logic [vcsa_pkg::CNT_W-1:0] SLOTS_C = vcsa_pkg::CNT_W'(vcsa_pkg::CACHE_SLOTS);
  localparam logic [vcsa_pkg::CNT_W-1:0] ONE_C   = vcsa_pkg::CNT_W'(1);

  vcsa_pkg::state_e                      state_q, state_d;
  vcsa_pkg::item_t                       item_q;
  logic [vcsa_pkg::CACHE_SLOTS-1:0]      match_q;
  logic [vcsa_pkg::LIMIT_W-1:0]          slot_limit_q;
  logic [vcsa_pkg::CNT_W-1:0]            count_q, count_d;
  logic [vcsa_pkg::CNT_W-1:0]            target_q, target_d;
  logic                                  res_valid_q, res_valid_d;
  vcsa_pkg::result_t                     res_q, res_d;
  logic                                  accept, batch_acc;
  logic                                  emit;

  // values above the slot count act as the slot count
  always_comb begin
    if (int'(slot_limit_q) > vcsa_pkg::CACHE_SLOTS) begin
      limit_o = SLOTS_C;
    end else begin
      limit_o = vcsa_pkg::CNT_W'(slot_limit_q);
    end
  end

  assign busy_o = (state_q == vcsa_pkg::ST_MATCH) || (state_q == vcsa_pkg::ST_WALK) ||
                  ((state_q == vcsa_pkg::ST_STORE) && item_q.last_in_batch);
  assign accept    = start_i && !busy_o;
  assign batch_acc = accept && (item_i.command == vcsa_pkg::CMD_BATCH);
  assign wr_en_o   = accept && (item_i.command == vcsa_pkg::CMD_WRITE);

  assign probe_o = '{buffer_id:     item_q.buffer_id,
                     vertex_number: item_q.vertex_number,
                     matrix_number: item_q.matrix_number};

  // highest matching slot wins
  always_comb begin
    store_entry_o = '0;
    for (int i = 0; i < vcsa_pkg::CACHE_SLOTS; i++) begin
      if (match_q[i]) begin
        store_entry_o.matched = 1'b1;
        store_entry_o.slot    = vcsa_pkg::SLOT_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vcsa_pkg::ST_IDLE: begin
        if (batch_acc) state_d = vcsa_pkg::ST_MATCH;
      end
      vcsa_pkg::ST_MATCH: begin
        state_d = vcsa_pkg::ST_STORE;
      end
      vcsa_pkg::ST_STORE: begin
        if (item_q.last_in_batch) begin
          state_d = vcsa_pkg::ST_WALK;
        end else if (batch_acc) begin
          state_d = vcsa_pkg::ST_MATCH;
        end else begin
          state_d = vcsa_pkg::ST_IDLE;
        end
      end
      vcsa_pkg::ST_WALK: begin
        if (emit && (count_q == ONE_C)) state_d = vcsa_pkg::ST_IDLE;
      end
      default: state_d = vcsa_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ctl_o       = '0;
    ctl_o.store_pos = count_q;
    emit        = 1'b0;
    res_d       = '0;
    count_d     = count_q;
    target_d    = target_q;
    case (state_q)
      vcsa_pkg::ST_MATCH: begin
        ctl_o.mark = (count_q < SLOTS_C);
      end
      vcsa_pkg::ST_STORE: begin
        if (count_q < SLOTS_C) begin
          ctl_o.store = 1'b1;
          count_d     = count_q + ONE_C;
        end
      end
      vcsa_pkg::ST_WALK: begin
        if (head_i.matched) begin
          emit                = 1'b1;
          res_d.assigned_slot = vcsa_pkg::SLOT_NUM_W'(head_i.slot);
          res_d.reused        = 1'b1;
          ctl_o.shift_batch   = 1'b1;
        end else if (target_q < limit_o) begin
          // skip slots taken by matches, one per cycle
          ctl_o.shift_used = 1'b1;
          target_d         = target_q + ONE_C;
          if (!head_used_i) begin
            emit                = 1'b1;
            res_d.assigned_slot = vcsa_pkg::SLOT_NUM_W'(target_q);
            ctl_o.shift_batch   = 1'b1;
          end
        end else begin
          emit              = 1'b1;
          res_d.overflow    = 1'b1;
          ctl_o.shift_batch = 1'b1;
        end
        if (emit) begin
          count_d           = count_q - ONE_C;
          res_d.last_result = (count_q == ONE_C);
          if (count_q == ONE_C) begin
            ctl_o.clear_used = 1'b1;
            target_d         = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_valid_d    = emit;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= vcsa_pkg::ST_IDLE;
      slot_limit_q <= vcsa_pkg::LIMIT_RESET;
      count_q      <= '0;
      target_q     <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      target_q    <= target_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        slot_limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_acc) item_q <= item_i;
    if (state_q == vcsa_pkg::ST_MATCH) match_q <= match_i;
    res_q <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/vertex_cache_slot_assigner.sv =====
// Vertex cache slot assigner: a write transaction (no busy) loads a resident
// slot; a batch transaction is matched against every slot below the limit. Each
// batch vertex passes the compare state followed by the highest-match select, and
// the next vertex can be taken during the select. The vertex marked last holds
// busy through its own compare and select and then the allocation walk, which
// runs through the batch at the head of the cell chain, skipping in-use slots.
// Results come at most one per cycle on result_valid_o for a single cycle each,
// registered and shown in the cycle after the walk step that makes them, so the
// last result shows in the first cycle with busy low; the receiver has no way to
// stall them.
// Depends on vcsa_pkg, vcsa_cell and vcsa_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module vertex_cache_slot_assigner (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire vcsa_pkg::item_t              item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [vcsa_pkg::LIMIT_W-1:0] cfg_wdata_i,
  output logic                              result_valid_o,
  output vcsa_pkg::result_t                 result_o
);

  vcsa_pkg::cell_ctl_t              ctl;
  logic [vcsa_pkg::CNT_W-1:0]       limit;
  vcsa_pkg::ident_t                 probe;
  vcsa_pkg::ident_t                 wr_ident;
  vcsa_pkg::entry_t                 store_entry;
  logic                             wr_en;
  logic [vcsa_pkg::CACHE_SLOTS-1:0] match_vec;
  vcsa_pkg::entry_t                 entry_w [vcsa_pkg::CACHE_SLOTS+1];
  logic                             used_w  [vcsa_pkg::CACHE_SLOTS+1];

  assign wr_ident = '{buffer_id:     item_i.buffer_id,
                      vertex_number: item_i.vertex_number,
                      matrix_number: item_i.matrix_number};

  // end of the chain shifts in empty entries and free slots
  assign entry_w[vcsa_pkg::CACHE_SLOTS] = '0;
  assign used_w[vcsa_pkg::CACHE_SLOTS]  = 1'b0;

  vcsa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .match_i        (match_vec),
    .head_i         (entry_w[0]),
    .head_used_i    (used_w[0]),
    .busy_o         (busy),
    .wr_en_o        (wr_en),
    .ctl_o          (ctl),
    .limit_o        (limit),
    .probe_o        (probe),
    .store_entry_o  (store_entry),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  for (genvar g = 0; g < vcsa_pkg::CACHE_SLOTS; g++) begin : g_cell
    vcsa_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .idx_i         (vcsa_pkg::CNT_W'(g)),
      .ctl_i         (ctl),
      .limit_i       (limit),
      .wr_en_i       (wr_en && (int'(item_i.slot_number) == g)),
      .wr_ident_i    (wr_ident),
      .probe_i       (probe),
      .store_entry_i (store_entry),
      .entry_next_i  (entry_w[g+1]),
      .used_next_i   (used_w[g+1]),
      .match_o       (match_vec[g]),
      .entry_o       (entry_w[g]),
      .used_o        (used_w[g])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/core/vcsa_checker.sv =====
// Port-level checks for the vertex cache slot assigner, bound to the top level.
// Depends on vcsa_pkg and vertex_cache_slot_assigner.
`timescale 1ns / 1ps
`default_nettype none

module vcsa_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire vcsa_pkg::item_t              item_i,
  input wire logic                         result_valid_o,
  input wire vcsa_pkg::result_t            result_o
);

  logic batch_acc;
  assign batch_acc = start && !busy && (item_i.command == vcsa_pkg::CMD_BATCH);

  // overflow results carry slot 0 and are never reuses
  a_overflow_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.overflow) |->
      (!result_o.reused && (result_o.assigned_slot == '0)))
    else $error("overflow result with slot or reuse set");

  // a non-final batch vertex holds busy through its compare state only
  a_batch_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_acc && !item_i.last_in_batch) |=> busy ##1 !busy)
    else $error("batch vertex not taken in two cycles");

  // the final vertex holds the block busy for the walk
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (batch_acc && item_i.last_in_batch) |=> busy)
    else $error("busy not raised after final batch vertex");

  // the last result of a batch is followed by a gap
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !result_valid_o)
    else $error("result directly after last result");

endmodule

bind vertex_cache_slot_assigner vcsa_checker u_vcsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

`default_nettype wire
